>>> rtl/trc_pkg.sv
// trc_pkg: shared types, codes and constants of the throttle cruise ramp controller
// no dependencies; used by trc_ctrl, trc_dp and the top level
package trc_pkg;

  // level quantization
  localparam logic [3:0]  MAX_LEVEL  = 4'd10;
  localparam int          LEVEL_W    = 4;
  localparam int          ADC_W      = 10;
  localparam int          NUM_W      = 16;
  localparam logic [4:0]  LEVEL_MULT = 5'(2 * MAX_LEVEL);

  // dac
  localparam int          DAC_W      = 12;
  localparam logic [12:0] LEVEL_STEP = 13'd410;
  localparam logic [11:0] DAC_FULL   = 12'hfff;

  // port widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_BRAKE  = 2'd1;
  localparam logic [1:0] OP_RAMP   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SPAN     = 2'd0;
  localparam logic [1:0] CFG_HOLD     = 2'd1;
  localparam logic [1:0] CFG_STEP     = 2'd2;
  localparam logic [1:0] CFG_MIN_INIT = 2'd3;

  // configuration reset values
  localparam logic [9:0]  SPAN_RST = 10'd600;
  localparam logic [15:0] HOLD_RST = 16'd5000;
  localparam logic [11:0] STEP_RST = 12'd21;
  localparam logic [9:0]  MIN_RST  = 10'd0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // one result item
  typedef struct packed {
    logic [3:0]  display_level;
    logic        dac_write;
    logic [11:0] dac_value;
  } result_t;

  // dac target for an effective level
  function automatic logic [11:0] level_target(input logic [3:0] lvl);
    logic [12:0] t;
    t = LEVEL_STEP * 13'(lvl);
    if (lvl >= MAX_LEVEL) begin
      return DAC_FULL;
    end else if (t > 13'(DAC_FULL)) begin
      return DAC_FULL;
    end else begin
      return t[11:0];
    end
  endfunction

endpackage

>>> rtl/throttle_cruise_ramp_controller.sv
// throttle_cruise_ramp_controller: top level with output register
// depends on trc_pkg, trc_ctrl, trc_dp
// sequence: an item is loaded, passes the quantizer and done states, and commit
//   loads the free output register; only released-brake samples run the quantizer
// throughput: one item at a time, next item accepted in the cycle after commit;
//   the quantizer loop (one add and compare per step) sets the sample time
// reset: synchronous active-low rst_n restores default configuration and idle state
module throttle_cruise_ramp_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [trc_pkg::IN_DATA_W-1:0]  in_tdata,   // adc_sample, brake_pin_high, now_ms
  input  logic [trc_pkg::IN_USER_W-1:0]  in_tuser,   // operation
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [trc_pkg::OUT_DATA_W-1:0] out_tdata,  // display_level, dac_value,
                                                     // dac_byte_high, dac_byte_low
  output logic [trc_pkg::OUT_USER_W-1:0] out_tuser,  // dac_write
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import trc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    result;
  logic       out_free;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  trc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  trc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata),
    .in_user   (in_tuser),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .result    (result)
  );

  // output register, loaded at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= {result.dac_value[3:0], 4'd0,
                      result.dac_value[11:4],
                      result.dac_value,
                      result.display_level};
      out_tuser_r <= result.dac_write;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> rtl/trc_ctrl.sv
// trc_ctrl: sequencer of one item: load, quantizer steps, commit
// depends on trc_pkg
module trc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  trc_pkg::dp_status_t status,
  output trc_pkg::ctrl_cmd_t  cmd
);
  import trc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/trc_dp.sv
// trc_dp: configuration and state registers, iterative level quantizer,
// cruise latch, target lookup and output ramp; depends on trc_pkg
module trc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trc_pkg::ctrl_cmd_t            cmd,
  output trc_pkg::dp_status_t           status,
  input  logic [trc_pkg::IN_DATA_W-1:0] in_data,
  input  logic [trc_pkg::IN_USER_W-1:0] in_user,
  input  logic                          cfg_we,
  input  logic [trc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output trc_pkg::result_t              result
);
  import trc_pkg::*;

  // configuration
  logic [9:0]  span_r;
  logic [15:0] hold_r;
  logic [11:0] step_r;

  // block state
  logic        brake_released_r, brake_released_nxt;
  logic [9:0]  sensor_min_r;
  logic [3:0]  throttle_level_r, throttle_level_nxt;
  logic [3:0]  cruise_level_r, cruise_level_nxt;
  logic [31:0] cruise_deadline_r, cruise_deadline_nxt;
  logic [11:0] target_r, target_nxt;
  logic [11:0] actual_r, actual_nxt;
  logic        wrote;

  // captured item
  logic [1:0]  op_r;
  logic        pin_r;
  logic [31:0] now_r;
  logic [9:0]  d_r;

  // quantizer
  logic [NUM_W-1:0] num_r, acc_r, acc_try, den;
  logic [3:0]       cnt_r;
  logic             run_r;

  // input field unpacking
  logic [9:0] in_sample;
  logic       take;
  logic [9:0] min_new;
  logic [9:0] d_new;

  assign in_sample = in_data[9:0];
  assign take      = (in_user == OP_SAMPLE) && brake_released_r;
  assign min_new   = (take && (in_sample < sensor_min_r)) ? in_sample : sensor_min_r;
  assign d_new     = in_sample - min_new;

  assign den     = NUM_W'({span_r, 1'b0});
  assign acc_try = acc_r + den;
  assign status.div_done = !run_r;

  // configuration registers and tracked minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r       <= SPAN_RST;
      hold_r       <= HOLD_RST;
      step_r       <= STEP_RST;
      sensor_min_r <= MIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SPAN:     span_r <= cfg_wdata[9:0];
        CFG_HOLD:     hold_r <= cfg_wdata;
        CFG_STEP:     step_r <= cfg_wdata[11:0];
        CFG_MIN_INIT: begin
          sensor_min_r <= cfg_wdata[9:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.load) begin
      sensor_min_r <= min_new;
    end
  end

  // item capture and repeated-add quantizer, capped at the top level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (cmd.load) begin
      run_r <= take;
    end else if (cmd.step && run_r) begin
      if ((cnt_r == MAX_LEVEL) || (acc_try > num_r)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_user;
      pin_r <= in_data[10];
      now_r <= in_data[42:11];
      d_r   <= d_new;
      num_r <= NUM_W'(d_new) * NUM_W'(LEVEL_MULT) + NUM_W'(span_r);
      acc_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step && run_r && (cnt_r != MAX_LEVEL) && (acc_try <= num_r)) begin
      acc_r <= acc_try;
      cnt_r <= cnt_r + 4'd1;
    end
  end

  // item effect on state
  logic [3:0]  lvl;
  logic [3:0]  eff_level;
  logic [12:0] ramp_sum;

  assign lvl      = (span_r == '0) ? ((d_r != '0) ? MAX_LEVEL : 4'd0) : cnt_r;
  assign ramp_sum = 13'(actual_r) + 13'(step_r);

  always_comb begin
    brake_released_nxt  = brake_released_r;
    throttle_level_nxt  = throttle_level_r;
    cruise_level_nxt    = cruise_level_r;
    cruise_deadline_nxt = cruise_deadline_r;
    target_nxt          = target_r;
    actual_nxt          = actual_r;
    wrote               = 1'b0;
    eff_level           = '0;
    case (op_r)
      OP_SAMPLE: begin
        if (brake_released_r) begin
          if (lvl == throttle_level_r) begin
            if ((cruise_level_r < throttle_level_r) && (cruise_deadline_r < now_r)) begin
              cruise_level_nxt = throttle_level_r;
            end
          end else begin
            if (lvl > throttle_level_r) begin
              cruise_level_nxt    = '0;
              cruise_deadline_nxt = now_r + 32'(hold_r);
            end
            throttle_level_nxt = lvl;
          end
        end
        eff_level  = (cruise_level_nxt != '0) ? cruise_level_nxt : throttle_level_nxt;
        target_nxt = level_target(eff_level);
      end
      OP_BRAKE: begin
        brake_released_nxt = pin_r;
        if (!pin_r) begin
          cruise_level_nxt   = '0;
          throttle_level_nxt = '0;
        end
      end
      OP_RAMP: begin
        if (actual_r != target_r) begin
          if (actual_r > target_r) begin
            actual_nxt = target_r;
          end else if (ramp_sum > 13'(DAC_FULL)) begin
            actual_nxt = DAC_FULL;
          end else begin
            actual_nxt = ramp_sum[11:0];
          end
          wrote = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers, updated at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_released_r  <= 1'b1;
      throttle_level_r  <= '0;
      cruise_level_r    <= '0;
      cruise_deadline_r <= '0;
      target_r          <= '0;
      actual_r          <= '0;
    end else if (cmd.commit) begin
      brake_released_r  <= brake_released_nxt;
      throttle_level_r  <= throttle_level_nxt;
      cruise_level_r    <= cruise_level_nxt;
      cruise_deadline_r <= cruise_deadline_nxt;
      target_r          <= target_nxt;
      actual_r          <= actual_nxt;
    end
  end

  // result seen after the item
  assign result.display_level = (cruise_level_nxt != '0) ? cruise_level_nxt : throttle_level_nxt;
  assign result.dac_write     = wrote;
  assign result.dac_value     = actual_nxt;

endmodule
